/* hdl/ismf_pkg.sv */
// Shared constants and codes for the inductive sample median filter.
// No dependencies; compiled first.
package ismf_pkg;

    localparam int OP_W     = 2;
    localparam int CH_W     = 2;
    localparam int WORD_W   = 16;
    localparam int ERR_W    = 4;
    localparam int SAMPLE_W = 28;
    localparam int UPPER_W  = SAMPLE_W - WORD_W;
    localparam int ENABLE_W = 4;
    localparam int MASK_W   = ENABLE_W * ERR_W;
    localparam int FAIL_W   = 2;

    localparam int SAMPLES_PER_WINDOW_DEF = 4;
    localparam int CHANNEL_COUNT_DEF      = 4;
    localparam int FAILURE_LIMIT_DEF      = 3;

    localparam logic [ENABLE_W-1:0] ENABLE_RESET = 4'h1;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_DATA        = 2'd0;
    localparam t_op OP_BUS_FAIL    = 2'd1;
    localparam t_op OP_STATUS_FAIL = 2'd2;
    localparam t_op OP_UNUSED      = 2'd3;

endpackage

/* hdl/ismf_if.sv */
// Handshake channels of the median filter: read words in, results out,
// and the channel enable write port. Depends on ismf_pkg.
interface ismf_sample_if;
    logic                            valid;
    logic                            ready;
    ismf_pkg::t_op                   operation;
    logic [ismf_pkg::CH_W-1:0]       channel;
    logic [ismf_pkg::WORD_W-1:0]     high_word;
    logic [ismf_pkg::WORD_W-1:0]     low_word;

    modport source (output valid, operation, channel, high_word, low_word, input ready);
    modport sink   (input valid, operation, channel, high_word, low_word, output ready);
endinterface

interface ismf_result_if;
    logic                            valid;
    logic                            ready;
    logic [ismf_pkg::CH_W-1:0]       result_channel;
    logic [ismf_pkg::SAMPLE_W-1:0]   median_value;
    logic [ismf_pkg::SAMPLE_W-1:0]   window_span;
    logic                            median_valid;
    logic [ismf_pkg::MASK_W-1:0]     error_mask;
    logic                            offline;
    logic                            ignored;

    modport source (output valid, result_channel, median_value, window_span, median_valid,
                    error_mask, offline, ignored, input ready);
    modport sink   (input valid, result_channel, median_value, window_span, median_valid,
                    error_mask, offline, ignored, output ready);
endinterface

interface ismf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ismf_pkg::ENABLE_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* hdl/inductive_sample_median_filter.sv */
// Median-and-span filter over per-channel sample windows of an inductance converter.
// Depends on ismf_pkg and the channels in ismf_if.
//
// One read word is taken every cycle unless an unaccepted result stalls the input register,
// and every word gives exactly one result word. The word is first held in an input
// register together with its channel's window row, read from the sample memory at the
// accepting edge (with a bypass for the sample written at that same edge); a single
// registered stage then updates error flags, fill counts and failure count, ranks the
// completed window with one compare per ordered sample pair and loads the result register. The
// sample memory is never cleared: fill counts decide which entries are live, so the block
// is ready straight out of reset. The channel enable register is written through the
// configuration port, which is always ready and should be used only while idle.
module inductive_sample_median_filter #(
    parameter int SAMPLES_PER_WINDOW = ismf_pkg::SAMPLES_PER_WINDOW_DEF,
    parameter int CHANNEL_COUNT      = ismf_pkg::CHANNEL_COUNT_DEF,
    parameter int FAILURE_LIMIT      = ismf_pkg::FAILURE_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ismf_sample_if.sink    i_sample,
    ismf_cfg_if.sink       i_cfg,
    ismf_result_if.source  o_result
);

    localparam int S       = SAMPLES_PER_WINDOW;
    localparam int FILL_W  = $clog2(S);
    localparam int CH_AW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int MID_HI  = S / 2;
    localparam int MID_LO  = (S % 2 == 1) ? S / 2 : S / 2 - 1;
    localparam int SW      = ismf_pkg::SAMPLE_W;
    localparam int EW      = ismf_pkg::ERR_W;

    typedef logic [S-1:0][SW-1:0] t_row;

    // sample memory, one row per channel
    t_row mem [CHANNEL_COUNT];

    // input register
    logic                           r_in_valid;
    ismf_pkg::t_op                  r_op;
    logic [ismf_pkg::CH_W-1:0]      r_ch;
    logic [ismf_pkg::WORD_W-1:0]    r_hi;
    logic [ismf_pkg::WORD_W-1:0]    r_lo;
    t_row                           r_row;

    // block state
    logic [ismf_pkg::ENABLE_W-1:0]         r_enable;
    logic [CHANNEL_COUNT-1:0][FILL_W-1:0]  r_fill;
    logic [ismf_pkg::MASK_W-1:0]           r_err;
    logic [ismf_pkg::FAIL_W-1:0]           r_fail;

    // result register
    logic                           r_out_valid;
    logic [ismf_pkg::CH_W-1:0]      r_res_ch;
    logic [SW-1:0]                  r_res_med;
    logic [SW-1:0]                  r_res_span;
    logic                           r_res_mvalid;
    logic [ismf_pkg::MASK_W-1:0]    r_res_mask;
    logic                           r_res_offline;
    logic                           r_res_ignored;

    logic                           in_accept;
    logic                           advance;
    logic [CH_AW-1:0]               rd_addr;
    logic                           row_bypass;

    // single-pass work on the registered word
    logic                                  n_fill_sel;
    logic [CHANNEL_COUNT-1:0][FILL_W-1:0]  n_fill;
    logic [ismf_pkg::MASK_W-1:0]           n_err;
    logic [ismf_pkg::FAIL_W-1:0]           n_fail;
    logic [ismf_pkg::FAIL_W-1:0]           fail_inc;
    logic                                  ch_ok;
    logic [CH_AW-1:0]                      ch_idx;
    logic [EW-1:0]                         err_bits;
    logic [SW-1:0]                         sample;
    logic [FILL_W-1:0]                     fill_idx;
    logic                                  wr_en;
    logic                                  failed;
    logic                                  n_mvalid;
    logic                                  n_offline;
    logic                                  n_ignored;
    t_row                                  win;
    logic [S-1:0][FILL_W-1:0]              rank;
    logic [SW-1:0]                         s_min;
    logic [SW-1:0]                         s_max;
    logic [SW-1:0]                         s_mid_lo;
    logic [SW-1:0]                         s_mid_hi;
    logic [SW:0]                           mid_sum;
    logic [SW-1:0]                         n_med;
    logic [SW-1:0]                         n_span;

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign in_accept      = i_sample.valid && i_sample.ready;
    assign i_cfg.ready    = 1'b1;

    assign rd_addr = (32'(i_sample.channel) < CHANNEL_COUNT) ?
                     i_sample.channel[CH_AW-1:0] : '0;

    assign row_bypass = advance && wr_en && (ch_idx == rd_addr);

    always_comb begin
        n_fill_sel = 1'b0;
        n_fill     = r_fill;
        n_err      = r_err;
        n_fail     = r_fail;
        fail_inc   = r_fail + 1'b1;
        ch_ok      = (32'(r_ch) < CHANNEL_COUNT) && r_enable[r_ch];
        ch_idx     = ch_ok ? r_ch[CH_AW-1:0] : '0;
        err_bits   = r_hi[ismf_pkg::WORD_W-1 -: EW];
        sample     = {r_hi[ismf_pkg::UPPER_W-1:0], r_lo};
        fill_idx   = r_fill[ch_idx];
        wr_en      = 1'b0;
        failed     = 1'b0;
        n_mvalid   = 1'b0;
        n_offline  = 1'b0;
        n_ignored  = 1'b0;

        case (r_op)
            ismf_pkg::OP_UNUSED: begin
                n_ignored = 1'b1;
            end
            ismf_pkg::OP_STATUS_FAIL: begin
                failed = 1'b1;
            end
            default: begin
                if (!ch_ok) begin
                    n_ignored = 1'b1;
                end else if (r_op == ismf_pkg::OP_BUS_FAIL) begin
                    failed         = 1'b1;
                    n_fill[ch_idx] = '0;
                end else if (err_bits != '0) begin
                    failed                  = 1'b1;
                    n_fill[ch_idx]          = '0;
                    n_err[r_ch*EW +: EW]    = r_err[r_ch*EW +: EW] | err_bits;
                end else begin
                    wr_en                = 1'b1;
                    n_fail               = '0;
                    n_err[r_ch*EW +: EW] = '0;
                    if (fill_idx == FILL_W'(S - 1)) begin
                        n_mvalid       = 1'b1;
                        n_fill[ch_idx] = '0;
                    end else begin
                        n_fill[ch_idx] = fill_idx + 1'b1;
                    end
                end
            end
        endcase

        if (failed) begin
            if (32'(fail_inc) >= FAILURE_LIMIT) begin
                n_offline  = 1'b1;
                n_fail     = '0;
                n_fill_sel = 1'b1;
            end else begin
                n_fail = fail_inc;
            end
        end
        if (n_fill_sel) begin
            n_fill = '0;
        end
    end

    // window ranking: rank ties by position so ranks form a permutation
    always_comb begin
        win          = r_row;
        win[S-1]     = sample;
        rank         = '0;
        s_min        = '0;
        s_max        = '0;
        s_mid_lo     = '0;
        s_mid_hi     = '0;
        for (int i = 0; i < S; i++) begin
            for (int j = 0; j < S; j++) begin
                if (j != i && (win[j] < win[i] || (win[j] == win[i] && j < i))) begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
        for (int i = 0; i < S; i++) begin
            if (rank[i] == FILL_W'(0))      s_min    = win[i];
            if (rank[i] == FILL_W'(S - 1))  s_max    = win[i];
            if (rank[i] == FILL_W'(MID_LO)) s_mid_lo = win[i];
            if (rank[i] == FILL_W'(MID_HI)) s_mid_hi = win[i];
        end
        mid_sum = {1'b0, s_mid_lo} + {1'b0, s_mid_hi};
        n_med   = n_mvalid ? mid_sum[SW:1] : '0;
        n_span  = n_mvalid ? (s_max - s_min) : '0;
    end

    // memory write from the working stage, row read at acceptance with bypass
    always_ff @(posedge i_clk) begin
        if (advance && wr_en) begin
            mem[ch_idx][fill_idx] <= sample;
        end
        if (in_accept) begin
            for (int k = 0; k < S; k++) begin
                r_row[k] <= (row_bypass && fill_idx == FILL_W'(k)) ? sample : mem[rd_addr][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op <= i_sample.operation;
            r_ch <= i_sample.channel;
            r_hi <= i_sample.high_word;
            r_lo <= i_sample.low_word;
        end
        if (advance) begin
            r_res_ch      <= r_ch;
            r_res_med     <= n_med;
            r_res_span    <= n_span;
            r_res_mvalid  <= n_mvalid;
            r_res_mask    <= n_err;
            r_res_offline <= n_offline;
            r_res_ignored <= n_ignored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_enable    <= ismf_pkg::ENABLE_RESET;
            r_fill      <= '0;
            r_err       <= '0;
            r_fail      <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_fill      <= n_fill;
                r_err       <= n_err;
                r_fail      <= n_fail;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_enable <= i_cfg.data;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.result_channel = r_res_ch;
    assign o_result.median_value   = r_res_med;
    assign o_result.window_span    = r_res_span;
    assign o_result.median_valid   = r_res_mvalid;
    assign o_result.error_mask     = r_res_mask;
    assign o_result.offline        = r_res_offline;
    assign o_result.ignored        = r_res_ignored;

`ifndef SYNTH
    // an offline word comes from a failure, never from a completed window
    a_offline_no_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.offline |-> !o_result.median_valid)
        else $error("offline result carries a median");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.ignored |-> !o_result.median_valid && !o_result.offline)
        else $error("ignored word changed state");

    a_offline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_offline |=> r_fill == '0 && r_fail == '0)
        else $error("windows not emptied after offline");

    a_fail_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fail) < FAILURE_LIMIT)
        else $error("failure count reached limit");

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_ch) && $stable(r_op)
                                   && $stable(r_row))
        else $error("held input word changed");
`endif

endmodule
